FILE: rtl/core/spbf_pkg.sv
package spbf_pkg;

	localparam int MAX_NODES_DEF    = 16;
	localparam int WEIGHT_BITS_DEF  = 16;
	localparam int NODE_FIELD_LIMIT = 16;
	localparam int NODE_W           = 4;
	localparam int CFG_W            = 5;

	localparam logic [CFG_W-1:0] NODES_RESET = 5'd16;

	localparam logic signed [31:0] DIST_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] DIST_MIN = 32'sh8000_0000;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_SOLVE = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [NODE_W-1:0]  from_node;
		logic [NODE_W-1:0]  to_node;
		logic signed [15:0] edge_weight;
		logic [NODE_W-1:0]  dest;
	} req_t;

	typedef struct packed {
		logic [NODE_W-1:0]  node;
		logic signed [31:0] distance;
		logic               reachable;
		logic               has_next_hop;
		logic [NODE_W-1:0]  next_hop;
		logic               last;
	} rsp_t;

	// one node record of the solver table
	typedef struct packed {
		logic signed [31:0] cost;
		logic               reach;
		logic               hop_valid;
		logic [NODE_W-1:0]  hop;
	} node_entry_t;

	typedef struct packed {
		logic mat_clear;
		logic mat_wr;
		logic node_init;
		logic init_dest;
		logic node_wb;
		logic issue;
		logic diag;
		logic acc_load;
		logic out_load;
		logic out_last;
	} dp_ctl_t;

endpackage

FILE: rtl/core/shortest_path_bellman_ford_unit.sv
// Bellman-Ford shortest paths toward one destination over a weight matrix of
// MAX_NODES x MAX_NODES entries (zero = no edge). A solve word with n nodes in
// use first seeds the node table, then runs n passes of n rows, each row a row
// load, one matrix read per edge through a single read port, a drain and a
// write-back, then reads out one result word per node, each waiting while the
// output register is stalled. After reset the matrix is cleared one entry a
// cycle, all MAX_NODES*MAX_NODES entries, while req_stall stays high;
// configuration writes are taken during that time.
// The last result word may still wait in the output register while the next
// request word is taken.
module shortest_path_bellman_ford_unit #(
	parameter int MAX_NODES   = spbf_pkg::MAX_NODES_DEF,
	parameter int WEIGHT_BITS = spbf_pkg::WEIGHT_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [spbf_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  spbf_pkg::req_t             req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output spbf_pkg::rsp_t             rsp
);

	localparam int NODES_USED = (MAX_NODES < spbf_pkg::NODE_FIELD_LIMIT) ?
		MAX_NODES : spbf_pkg::NODE_FIELD_LIMIT;
	localparam int NIDX_W = $clog2(NODES_USED);
	localparam int MAT_AW = $clog2(MAX_NODES * MAX_NODES);

	spbf_pkg::dp_ctl_t ctl;
	logic [MAT_AW-1:0] mat_addr;
	logic [NIDX_W-1:0] node_raddr;
	logic [NIDX_W-1:0] node_waddr;
	logic              out_free;

	spbf_ctrl #(
		.MAX_NODES(MAX_NODES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_cmd   (req.cmd),
		.req_dest  (req.dest),
		.out_free  (out_free),
		.ctl       (ctl),
		.mat_addr  (mat_addr),
		.node_raddr(node_raddr),
		.node_waddr(node_waddr)
	);

	spbf_dp #(
		.MAX_NODES  (MAX_NODES),
		.WEIGHT_BITS(WEIGHT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.ctl       (ctl),
		.mat_addr  (mat_addr),
		.node_raddr(node_raddr),
		.node_waddr(node_waddr),
		.out_free  (out_free),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

endmodule

FILE: rtl/core/spbf_ctrl.sv
module spbf_ctrl #(
	parameter int MAX_NODES = spbf_pkg::MAX_NODES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [spbf_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic                          req_cmd,
	input  logic [spbf_pkg::NODE_W-1:0]   req_dest,
	input  logic                          out_free,
	output spbf_pkg::dp_ctl_t             ctl,
	output logic [$clog2(MAX_NODES*MAX_NODES)-1:0] mat_addr,
	output logic [$clog2((MAX_NODES < spbf_pkg::NODE_FIELD_LIMIT) ?
		MAX_NODES : spbf_pkg::NODE_FIELD_LIMIT)-1:0] node_raddr,
	output logic [$clog2((MAX_NODES < spbf_pkg::NODE_FIELD_LIMIT) ?
		MAX_NODES : spbf_pkg::NODE_FIELD_LIMIT)-1:0] node_waddr
);

	localparam int NODES_USED = (MAX_NODES < spbf_pkg::NODE_FIELD_LIMIT) ?
		MAX_NODES : spbf_pkg::NODE_FIELD_LIMIT;
	localparam int NIDX_W    = $clog2(NODES_USED);
	localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;
	localparam int MAT_AW    = $clog2(MAT_DEPTH);
	localparam logic [MAT_AW-1:0] MAT_LAST = MAT_AW'(MAT_DEPTH - 1);

	typedef enum logic [8:0] {
		ST_CLEAR    = 9'b000000001,
		ST_IDLE     = 9'b000000010,
		ST_INIT     = 9'b000000100,
		ST_ROW_LOAD = 9'b000001000,
		ST_SWEEP    = 9'b000010000,
		ST_DRAIN    = 9'b000100000,
		ST_WB       = 9'b001000000,
		ST_OUT_READ = 9'b010000000,
		ST_OUT_PUSH = 9'b100000000
	} state_t;

	state_t                      state_q;
	logic [MAT_AW-1:0]           clr_q;
	logic [NIDX_W-1:0]           col_q;
	logic [NIDX_W-1:0]           row_q;
	logic [NIDX_W-1:0]           pass_q;
	logic [spbf_pkg::CFG_W-1:0]  cfg_q;
	logic [spbf_pkg::NODE_W-1:0] dest_q;
	logic [NIDX_W-1:0]           nlast;
	logic                        accept;
	logic                        col_end;

	// clamp the node count to 1..NODES_USED, kept as last index
	always_comb begin
		if (cfg_q == '0) begin
			nlast = '0;
		end else if (6'(cfg_q) > 6'(NODES_USED)) begin
			nlast = NIDX_W'(NODES_USED - 1);
		end else begin
			nlast = NIDX_W'(cfg_q - 5'd1);
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign accept    = req_valid && (state_q == ST_IDLE);
	assign col_end   = (col_q == nlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			pass_q  <= '0;
			cfg_q   <= spbf_pkg::NODES_RESET;
			dest_q  <= '0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + MAT_AW'(1);
					if (clr_q == MAT_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && req_cmd == spbf_pkg::CMD_SOLVE) begin
						dest_q  <= req_dest;
						col_q   <= '0;
						state_q <= ST_INIT;
					end
				end
				ST_INIT: begin
					if (col_end) begin
						col_q   <= '0;
						row_q   <= '0;
						pass_q  <= '0;
						state_q <= ST_ROW_LOAD;
					end else begin
						col_q <= col_q + NIDX_W'(1);
					end
				end
				ST_ROW_LOAD: begin
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (col_end) begin
						col_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						col_q <= col_q + NIDX_W'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					if (row_q == nlast) begin
						row_q <= '0;
						if (pass_q == nlast) begin
							pass_q  <= '0;
							state_q <= ST_OUT_READ;
						end else begin
							pass_q  <= pass_q + NIDX_W'(1);
							state_q <= ST_ROW_LOAD;
						end
					end else begin
						row_q   <= row_q + NIDX_W'(1);
						state_q <= ST_ROW_LOAD;
					end
				end
				ST_OUT_READ: begin
					state_q <= ST_OUT_PUSH;
				end
				ST_OUT_PUSH: begin
					if (out_free) begin
						if (col_end) begin
							col_q   <= '0;
							state_q <= ST_IDLE;
						end else begin
							col_q   <= col_q + NIDX_W'(1);
							state_q <= ST_OUT_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		ctl        = '0;
		mat_addr   = '0;
		node_raddr = '0;
		node_waddr = '0;
		case (state_q)
			ST_CLEAR: begin
				ctl.mat_clear = 1'b1;
				mat_addr      = clr_q;
			end
			ST_IDLE: begin
				ctl.mat_wr = accept && (req_cmd == spbf_pkg::CMD_WRITE);
			end
			ST_INIT: begin
				ctl.node_init = 1'b1;
				ctl.init_dest = (8'(dest_q) == 8'(col_q));
				node_waddr    = col_q;
			end
			ST_ROW_LOAD: begin
				node_raddr = row_q;
			end
			ST_SWEEP: begin
				node_raddr   = col_q;
				mat_addr     = MAT_AW'(row_q) * MAT_AW'(MAX_NODES) + MAT_AW'(col_q);
				ctl.issue    = 1'b1;
				ctl.diag     = (col_q == row_q);
				ctl.acc_load = (col_q == '0);
			end
			ST_WB: begin
				ctl.node_wb = 1'b1;
				node_waddr  = row_q;
			end
			ST_OUT_READ: begin
				node_raddr = col_q;
			end
			ST_OUT_PUSH: begin
				node_raddr   = col_q;
				ctl.out_load = out_free;
				ctl.out_last = col_end;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

endmodule

FILE: rtl/core/spbf_dp.sv
module spbf_dp #(
	parameter int MAX_NODES   = spbf_pkg::MAX_NODES_DEF,
	parameter int WEIGHT_BITS = spbf_pkg::WEIGHT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spbf_pkg::req_t       req,
	input  spbf_pkg::dp_ctl_t    ctl,
	input  logic [$clog2(MAX_NODES*MAX_NODES)-1:0] mat_addr,
	input  logic [$clog2((MAX_NODES < spbf_pkg::NODE_FIELD_LIMIT) ?
		MAX_NODES : spbf_pkg::NODE_FIELD_LIMIT)-1:0] node_raddr,
	input  logic [$clog2((MAX_NODES < spbf_pkg::NODE_FIELD_LIMIT) ?
		MAX_NODES : spbf_pkg::NODE_FIELD_LIMIT)-1:0] node_waddr,
	output logic                 out_free,
	output spbf_pkg::rsp_t       rsp,
	output logic                 rsp_valid,
	input  logic                 rsp_stall
);

	localparam int NODES_USED = (MAX_NODES < spbf_pkg::NODE_FIELD_LIMIT) ?
		MAX_NODES : spbf_pkg::NODE_FIELD_LIMIT;
	localparam int NIDX_W    = $clog2(NODES_USED);
	localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;
	localparam int MAT_AW    = $clog2(MAT_DEPTH);

	logic signed [WEIGHT_BITS-1:0] mat_mem [MAT_DEPTH];
	logic signed [WEIGHT_BITS-1:0] w_q;
	logic                          mat_we;
	logic [MAT_AW-1:0]             mat_waddr;
	logic signed [WEIGHT_BITS-1:0] mat_wdata;
	logic signed [31:0]            w_ext;
	logic                          in_range;

	spbf_pkg::node_entry_t node_mem [NODES_USED];
	spbf_pkg::node_entry_t node_q;
	spbf_pkg::node_entry_t acc_q;
	spbf_pkg::node_entry_t init_entry;
	spbf_pkg::node_entry_t src;

	logic              valid_s1;
	logic              diag_s1;
	logic [NIDX_W-1:0] v_s1;

	logic signed [33:0] sum;
	logic signed [31:0] sat;
	logic               take;

	spbf_pkg::rsp_t rsp_q;
	logic           rsp_valid_q;

	// edge write: wrap the weight to the stored width, drop out-of-range nodes
	assign w_ext    = 32'(req.edge_weight);
	assign in_range = (32'(req.from_node) < 32'(MAX_NODES)) &&
		(32'(req.to_node) < 32'(MAX_NODES));
	assign mat_we    = ctl.mat_clear || (ctl.mat_wr && in_range);
	assign mat_waddr = ctl.mat_clear ? mat_addr :
		MAT_AW'(req.from_node) * MAT_AW'(MAX_NODES) + MAT_AW'(req.to_node);
	assign mat_wdata = ctl.mat_clear ? '0 : w_ext[WEIGHT_BITS-1:0];

	always_ff @(posedge clk) begin
		if (mat_we) begin
			mat_mem[mat_waddr] <= mat_wdata;
		end
		w_q <= mat_mem[mat_addr];
	end

	always_comb begin
		init_entry           = '0;
		init_entry.cost      = ctl.init_dest ? 32'sd0 : spbf_pkg::DIST_MAX;
		init_entry.reach     = ctl.init_dest;
	end

	always_ff @(posedge clk) begin
		if (ctl.node_init) begin
			node_mem[node_waddr] <= init_entry;
		end else if (ctl.node_wb) begin
			node_mem[node_waddr] <= acc_q;
		end
		node_q <= node_mem[node_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			diag_s1  <= 1'b0;
		end else begin
			valid_s1 <= ctl.issue;
			diag_s1  <= ctl.diag;
		end
	end

	always_ff @(posedge clk) begin
		v_s1 <= node_raddr;
	end

	// relax one edge; the row's own node comes from the accumulator
	assign src = diag_s1 ? acc_q : node_q;
	assign sum = 34'(src.cost) + 34'(w_q);

	always_comb begin
		if (sum > 34'(spbf_pkg::DIST_MAX)) begin
			sat = spbf_pkg::DIST_MAX;
		end else if (sum < 34'(spbf_pkg::DIST_MIN)) begin
			sat = spbf_pkg::DIST_MIN;
		end else begin
			sat = sum[31:0];
		end
	end

	assign take = valid_s1 && (w_q != '0) && src.reach &&
		(!acc_q.reach || (sat < acc_q.cost));

	always_ff @(posedge clk) begin
		if (ctl.acc_load) begin
			acc_q <= node_q;
		end else if (take) begin
			acc_q.cost      <= sat;
			acc_q.reach     <= 1'b1;
			acc_q.hop_valid <= 1'b1;
			acc_q.hop       <= spbf_pkg::NODE_W'(v_s1);
		end
	end

	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			rsp_q.node         <= spbf_pkg::NODE_W'(node_raddr);
			rsp_q.distance     <= node_q.cost;
			rsp_q.reachable    <= node_q.reach;
			rsp_q.has_next_hop <= node_q.hop_valid;
			rsp_q.next_hop     <= node_q.hop;
			rsp_q.last         <= ctl.out_last;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

FILE: tb/tb_shortest_path_bellman_ford_unit.sv
module tb_shortest_path_bellman_ford_unit;

	localparam int QUIET_LIMIT = 30000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TARGET_WORDS = 140;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [spbf_pkg::CFG_W-1:0] cfg_wdata;
	logic req_valid;
	logic req_stall;
	spbf_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	spbf_pkg::rsp_t rsp;

	shortest_path_bellman_ford_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	// predictor state
	logic signed [15:0] edge_w [spbf_pkg::MAX_NODES_DEF][spbf_pkg::MAX_NODES_DEF];
	logic [spbf_pkg::CFG_W-1:0] nodes_reg;
	spbf_pkg::rsp_t expected_routes [$];

	int mismatch_count;
	int words_sent;
	int quiet_cycles;
	int rsp_hold_cycles;
	bit req_gaps_on;
	bit rsp_gaps_on;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int active_nodes();
		int n;
		n = int'(nodes_reg);
		if (n == 0) n = 1;
		if (n > spbf_pkg::MAX_NODES_DEF) n = spbf_pkg::MAX_NODES_DEF;
		return n;
	endfunction

	function automatic void solve_routes(logic [spbf_pkg::NODE_W-1:0] dst);
		longint path_len [spbf_pkg::MAX_NODES_DEF];
		bit reach [spbf_pkg::MAX_NODES_DEF];
		bit hop_ok [spbf_pkg::MAX_NODES_DEF];
		logic [spbf_pkg::NODE_W-1:0] hop [spbf_pkg::MAX_NODES_DEF];
		longint sum;
		int n;
		spbf_pkg::rsp_t r;
		n = active_nodes();
		for (int u = 0; u < n; u++) begin
			path_len[u] = longint'(spbf_pkg::DIST_MAX);
			reach[u] = 1'b0;
			hop_ok[u] = 1'b0;
			hop[u] = '0;
		end
		if (int'(dst) < n) begin
			path_len[dst] = 0;
			reach[dst] = 1'b1;
		end
		for (int p = 0; p < n; p++) begin
			for (int u = 0; u < n; u++) begin
				for (int v = 0; v < n; v++) begin
					if (edge_w[u][v] == 0 || !reach[v]) continue;
					sum = path_len[v] + longint'(edge_w[u][v]);
					if (sum > longint'(spbf_pkg::DIST_MAX)) sum = longint'(spbf_pkg::DIST_MAX);
					if (sum < longint'(spbf_pkg::DIST_MIN)) sum = longint'(spbf_pkg::DIST_MIN);
					if (!reach[u] || sum < path_len[u]) begin
						path_len[u] = sum;
						reach[u] = 1'b1;
						hop_ok[u] = 1'b1;
						hop[u] = v[spbf_pkg::NODE_W-1:0];
					end
				end
			end
		end
		for (int k = 0; k < n; k++) begin
			r.node = k[spbf_pkg::NODE_W-1:0];
			r.distance = path_len[k][31:0];
			r.reachable = reach[k];
			r.has_next_hop = hop_ok[k];
			r.next_hop = hop_ok[k] ? hop[k] : '0;
			r.last = (k == n - 1);
			expected_routes.push_back(r);
		end
	endfunction

	function automatic void apply_word(spbf_pkg::req_t w);
		if (w.cmd == spbf_pkg::CMD_WRITE)
			edge_w[w.from_node][w.to_node] = w.edge_weight;
		else
			solve_routes(w.dest);
	endfunction

	function automatic logic signed [15:0] pick_weight();
		case ($urandom_range(0, 9))
			0: return 16'($urandom_range(0, 65535));
			1: begin
				case ($urandom_range(0, 3))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return -16'sd1;
					default: return 16'sd1;
				endcase
			end
			2: return '0;
			default: return 16'(int'($urandom_range(0, 45)) - 5);
		endcase
	endfunction

	function automatic spbf_pkg::req_t make_write(int u, int v, logic signed [15:0] wt);
		spbf_pkg::req_t w;
		w.cmd = spbf_pkg::CMD_WRITE;
		w.from_node = u[spbf_pkg::NODE_W-1:0];
		w.to_node = v[spbf_pkg::NODE_W-1:0];
		w.edge_weight = wt;
		w.dest = spbf_pkg::NODE_W'($urandom_range(0, 15));
		return w;
	endfunction

	function automatic spbf_pkg::req_t make_solve(int d);
		spbf_pkg::req_t w;
		w.cmd = spbf_pkg::CMD_SOLVE;
		w.from_node = spbf_pkg::NODE_W'($urandom_range(0, 15));
		w.to_node = spbf_pkg::NODE_W'($urandom_range(0, 15));
		w.edge_weight = 16'($urandom_range(0, 65535));
		w.dest = d[spbf_pkg::NODE_W-1:0];
		return w;
	endfunction

	task automatic report_mismatch(string msg);
		$display("mismatch: %s", msg);
		mismatch_count++;
	endtask

	task automatic send_word(spbf_pkg::req_t w);
		int gap;
		gap = req_gaps_on ? $urandom_range(0, 7) : 0;
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_valid <= 1'b1;
		req <= w;
		do @(posedge clk); while (req_stall);
		apply_word(w);
		words_sent++;
	endtask

	// drop valid, wait for all results, then let the block go idle
	task automatic finish_phase();
		@(negedge clk);
		req_valid <= 1'b0;
		while (expected_routes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_nodes(logic [spbf_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		nodes_reg = value;
	endtask

	task automatic test_directed();
		req_gaps_on = 1'b1;
		rsp_gaps_on = 1'b1;
		set_nodes(5'd4);
		send_word(make_write(1, 0, 16'sd5));
		send_word(make_write(2, 1, -16'sd3));
		send_word(make_write(3, 2, 16'sh7FFF));
		send_word(make_write(3, 0, 16'sh8000));
		send_word(make_write(2, 0, 16'sd100));
		send_word(make_write(0, 1, 16'sd0));
		// stale edges outside the four nodes in use
		send_word(make_write(15, 15, -16'sd1));
		send_word(make_write(15, 0, 16'sd1));
		send_word(make_solve(0));
		send_word(make_solve(2));
		send_word(make_solve(15));
		finish_phase();
		// zero acts as one node
		set_nodes(5'd0);
		send_word(make_solve(0));
		send_word(make_solve(1));
		finish_phase();
		// above the maximum acts as the maximum
		req_gaps_on = 1'b0;
		rsp_gaps_on = 1'b0;
		set_nodes(5'd31);
		send_word(make_solve(15));
		finish_phase();
		set_nodes(5'd16);
		send_word(make_write(0, 15, 16'sd7));
		send_word(make_solve(0));
		send_word(make_write(15, 15, 16'sd0));
		send_word(make_write(3, 0, 16'sd0));
		send_word(make_solve(15));
		finish_phase();
		set_nodes(5'd2);
		send_word(make_solve(1));
		finish_phase();
	endtask

	task automatic test_backpressure();
		req_gaps_on = 1'b0;
		rsp_gaps_on = 1'b1;
		set_nodes(5'd3);
		rsp_hold_cycles = 300;
		send_word(make_solve(0));
		send_word(make_write(1, 0, 16'sd2));
		send_word(make_write(2, 1, 16'sd3));
		send_word(make_write(2, 0, 16'sd9));
		send_word(make_solve(1));
		send_word(make_solve(2));
		send_word(make_write(0, 2, -16'sd4));
		send_word(make_solve(0));
		send_word(make_solve(1));
		finish_phase();
	endtask

	task automatic test_random_graphs();
		int n;
		int cnt;
		logic [spbf_pkg::CFG_W-1:0] cfg_val;
		while (words_sent < TARGET_WORDS) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 6);
			cfg_val = spbf_pkg::CFG_W'(n);
			if (n == 1 && $urandom_range(0, 1)) cfg_val = 5'd0;
			if (n == 16 && $urandom_range(0, 1))
				cfg_val = spbf_pkg::CFG_W'($urandom_range(17, 31));
			set_nodes(cfg_val);
			req_gaps_on = ($urandom_range(0, 3) != 0);
			rsp_gaps_on = ($urandom_range(0, 3) != 0);
			cnt = $urandom_range(2, 10);
			repeat (cnt) begin
				if ($urandom_range(0, 7) == 0)
					send_word(make_write($urandom_range(0, 15), $urandom_range(0, 15),
						pick_weight()));
				else
					send_word(make_write($urandom_range(0, n - 1), $urandom_range(0, n - 1),
						pick_weight()));
			end
			cnt = $urandom_range(1, 2);
			repeat (cnt) begin
				if ($urandom_range(0, 5) == 0)
					send_word(make_solve($urandom_range(0, 15)));
				else
					send_word(make_solve($urandom_range(0, n - 1)));
				if ($urandom_range(0, 2) == 0)
					send_word(make_write($urandom_range(0, n - 1), $urandom_range(0, n - 1),
						pick_weight()));
			end
			finish_phase();
		end
	endtask

	// receiver: random stall per word, plus a long hold when asked
	initial begin
		int gap;
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			gap = rsp_gaps_on ? $urandom_range(0, 7) : 0;
			if (rsp_hold_cycles > 0) begin
				rsp_stall <= 1'b1;
				repeat (rsp_hold_cycles) @(negedge clk);
				rsp_hold_cycles = 0;
			end else if (gap > 0) begin
				rsp_stall <= 1'b1;
				repeat (gap) @(negedge clk);
			end
			rsp_stall <= 1'b0;
			@(posedge clk);
			while (!rsp_valid && rsp_hold_cycles == 0) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		spbf_pkg::rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_routes.size() == 0) begin
				report_mismatch($sformatf("result word for node %0d with none expected",
					rsp.node));
			end else begin
				want = expected_routes.pop_front();
				if (rsp.node !== want.node)
					report_mismatch($sformatf("node got %0d want %0d", rsp.node, want.node));
				if (rsp.distance !== want.distance)
					report_mismatch($sformatf("node %0d distance got %0d want %0d",
						want.node, rsp.distance, want.distance));
				if (rsp.reachable !== want.reachable)
					report_mismatch($sformatf("node %0d reachable got %b want %b",
						want.node, rsp.reachable, want.reachable));
				if (rsp.has_next_hop !== want.has_next_hop)
					report_mismatch($sformatf("node %0d has_next_hop got %b want %b",
						want.node, rsp.has_next_hop, want.has_next_hop));
				if (rsp.next_hop !== want.next_hop)
					report_mismatch($sformatf("node %0d next_hop got %0d want %0d",
						want.node, rsp.next_hop, want.next_hop));
				if (rsp.last !== want.last)
					report_mismatch($sformatf("node %0d last got %b want %b",
						want.node, rsp.last, want.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		req = '0;
		mismatch_count = 0;
		words_sent = 0;
		quiet_cycles = 0;
		rsp_hold_cycles = 0;
		req_gaps_on = 1'b0;
		rsp_gaps_on = 1'b0;
		nodes_reg = spbf_pkg::NODES_RESET;
		for (int u = 0; u < spbf_pkg::MAX_NODES_DEF; u++)
			for (int v = 0; v < spbf_pkg::MAX_NODES_DEF; v++)
				edge_w[u][v] = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_backpressure();
		test_random_graphs();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_routes.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
